>>> design/canopen_lss_slave_frame_handler_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef CANOPEN_LSS_SLAVE_FRAME_HANDLER_UNIT_MACROS_SVH
`define CANOPEN_LSS_SLAVE_FRAME_HANDLER_UNIT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define CLSH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clsh check failed");

// Next-cycle implication, reset masks the check.
`define CLSH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clsh check failed");

`endif

>>> design/clsh_pkg.sv
`default_nettype none

package clsh_pkg;

    localparam logic [10:0] LSS_RX_ID      = 11'h7E5;
    localparam logic [10:0] NMT_ID         = 11'h000;
    localparam logic [3:0]  LSS_LEN        = 4'd8;
    localparam logic [3:0]  NMT_LEN        = 4'd2;
    localparam logic [7:0]  NMT_RESET_COMM = 8'd130;

    localparam logic [7:0] CS_SWITCH_GLOBAL = 8'h04;
    localparam logic [7:0] CS_SEL_VENDOR    = 8'h40;
    localparam logic [7:0] CS_SEL_PRODUCT   = 8'h41;
    localparam logic [7:0] CS_SEL_REVISION  = 8'h42;
    localparam logic [7:0] CS_SEL_SERIAL    = 8'h43;
    localparam logic [7:0] CS_SEL_CONFIRM   = 8'h44;
    localparam logic [7:0] CS_CFG_NODE_ID   = 8'h11;
    localparam logic [7:0] CS_CFG_TIMING    = 8'h13;
    localparam logic [7:0] CS_ACT_TIMING    = 8'h15;
    localparam logic [7:0] CS_STORE         = 8'h17;

    localparam logic [7:0] MODE_WAITING = 8'd0;
    localparam logic [7:0] MODE_CONFIG  = 8'd1;

    localparam logic [7:0] ERR_NONE = 8'd0;
    localparam logic [7:0] ERR_FAIL = 8'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ERROR = 2'd1;
    localparam logic [1:0] ST_RATE  = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_VENDOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRODUCT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVISION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SERIAL   = 3'd3;

    localparam int IN_W  = 80;
    localparam int OUT_W = 80;
    localparam int RATE_W = 20;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        K_NONE       = 4'd0,
        K_GLOBAL     = 4'd1,
        K_SEL_VENDOR = 4'd2,
        K_SEL_PROD   = 4'd3,
        K_SEL_REV    = 4'd4,
        K_SEL_SERIAL = 4'd5,
        K_CFG_NODE   = 4'd6,
        K_CFG_TIMING = 4'd7,
        K_ACT_TIMING = 4'd8,
        K_STORE      = 4'd9,
        K_NMT        = 4'd10
    } t_kind;

    // Classified request, as queued between front and back
    typedef struct packed {
        t_kind             kind;
        logic              id_match;
        logic              node_ok;
        logic              rate_ok;
        logic [RATE_W-1:0] rate;
        logic [7:0]        arg1;
        logic [7:0]        arg2;
    } t_cmd;

    // Result item, tx_valid in the lowest bit
    typedef struct packed {
        logic [1:0]        status;
        logic [15:0]       switch_delay;
        logic              rate_switch;
        logic [RATE_W-1:0] active_rate;
        logic [7:0]        pending_node;
        logic [6:0]        active_node;
        logic              mode_notify;
        logic [7:0]        mode;
        logic [7:0]        tx_error;
        logic [7:0]        tx_command;
        logic              tx_valid;
    } t_result;

    // Bit timing table 0; zero marks an index without a rate
    function automatic logic [RATE_W-1:0] rate_lookup(input logic [7:0] idx);
        logic [RATE_W-1:0] r;
        case (idx)
            8'd0:    r = RATE_W'(1000000);
            8'd1:    r = RATE_W'(800000);
            8'd2:    r = RATE_W'(500000);
            8'd3:    r = RATE_W'(250000);
            8'd4:    r = RATE_W'(125000);
            8'd6:    r = RATE_W'(50000);
            8'd7:    r = RATE_W'(20000);
            8'd8:    r = RATE_W'(10000);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/clsh_front.sv
`default_nettype none

module clsh_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [clsh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [31:0]                     i_cfg_data,
    input  wire logic [10:0]                     i_frame_id,
    input  wire logic [3:0]                      i_frame_len,
    input  wire logic [63:0]                     i_bytes,
    output clsh_pkg::t_cmd                       o_cmd
);

    logic [31:0] r_vendor;
    logic [31:0] r_product;
    logic [31:0] r_revision;
    logic [31:0] r_serial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vendor   <= '0;
            r_product  <= '0;
            r_revision <= '0;
            r_serial   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                clsh_pkg::REG_VENDOR:   r_vendor   <= i_cfg_data;
                clsh_pkg::REG_PRODUCT:  r_product  <= i_cfg_data;
                clsh_pkg::REG_REVISION: r_revision <= i_cfg_data;
                clsh_pkg::REG_SERIAL:   r_serial   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [7:0]  b0, b1, b2;
    logic [31:0] word;
    logic [31:0] want;
    logic [clsh_pkg::RATE_W-1:0] rate;

    assign b0   = i_bytes[7:0];
    assign b1   = i_bytes[15:8];
    assign b2   = i_bytes[23:16];
    // identity word is little-endian over bytes 1..4
    assign word = i_bytes[39:8];
    assign rate = clsh_pkg::rate_lookup(b2);

    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = clsh_pkg::K_NONE;
        want       = r_vendor;
        if (i_frame_id == clsh_pkg::LSS_RX_ID && i_frame_len == clsh_pkg::LSS_LEN) begin
            case (b0)
                clsh_pkg::CS_SWITCH_GLOBAL: o_cmd.kind = clsh_pkg::K_GLOBAL;
                clsh_pkg::CS_SEL_VENDOR:    o_cmd.kind = clsh_pkg::K_SEL_VENDOR;
                clsh_pkg::CS_SEL_PRODUCT: begin
                    o_cmd.kind = clsh_pkg::K_SEL_PROD;
                    want       = r_product;
                end
                clsh_pkg::CS_SEL_REVISION: begin
                    o_cmd.kind = clsh_pkg::K_SEL_REV;
                    want       = r_revision;
                end
                clsh_pkg::CS_SEL_SERIAL: begin
                    o_cmd.kind = clsh_pkg::K_SEL_SERIAL;
                    want       = r_serial;
                end
                clsh_pkg::CS_CFG_NODE_ID:   o_cmd.kind = clsh_pkg::K_CFG_NODE;
                clsh_pkg::CS_CFG_TIMING:    o_cmd.kind = clsh_pkg::K_CFG_TIMING;
                clsh_pkg::CS_ACT_TIMING:    o_cmd.kind = clsh_pkg::K_ACT_TIMING;
                clsh_pkg::CS_STORE:         o_cmd.kind = clsh_pkg::K_STORE;
                default:                    o_cmd.kind = clsh_pkg::K_NONE;
            endcase
        end else if (i_frame_id == clsh_pkg::NMT_ID && i_frame_len == clsh_pkg::NMT_LEN
                     && b0 == clsh_pkg::NMT_RESET_COMM) begin
            o_cmd.kind = clsh_pkg::K_NMT;
        end
        o_cmd.id_match = (want == word);
        o_cmd.node_ok  = b1 inside {[8'd1:8'd127], 8'hFF};
        o_cmd.rate_ok  = (b1 == 8'd0) && (rate != '0);
        o_cmd.rate     = rate;
        o_cmd.arg1     = b1;
        o_cmd.arg2     = b2;
    end

endmodule

`default_nettype wire

>>> design/clsh_queue.sv
`default_nettype none

module clsh_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_wr_valid,
    output logic           o_wr_ready,
    input  clsh_pkg::t_cmd i_wr_data,
    output logic           o_rd_valid,
    input  wire logic      i_rd_ready,
    output clsh_pkg::t_cmd o_rd_data
);

    localparam int CNT_W = clsh_pkg::QUEUE_AW + 1;
    localparam logic [clsh_pkg::QUEUE_AW-1:0] LAST = clsh_pkg::QUEUE_AW'(clsh_pkg::QUEUE_DEPTH - 1);

    clsh_pkg::t_cmd r_mem [clsh_pkg::QUEUE_DEPTH];
    logic [clsh_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [clsh_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [CNT_W-1:0]              r_count;
    logic push, pop;

    assign o_wr_ready = (r_count != CNT_W'(clsh_pkg::QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/clsh_back.sv
`default_nettype none

module clsh_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cmd_valid,
    output logic              o_cmd_ready,
    input  clsh_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    input  wire logic         i_ready,
    output clsh_pkg::t_result o_result
);

    localparam logic [2:0] STAGE_NONE     = 3'd0;
    localparam logic [2:0] STAGE_VENDOR   = 3'd1;
    localparam logic [2:0] STAGE_PRODUCT  = 3'd2;
    localparam logic [2:0] STAGE_REVISION = 3'd3;
    localparam logic [2:0] STAGE_SERIAL   = 3'd4;

    logic [7:0]                  r_mode, n_mode;
    logic [2:0]                  r_stage, n_stage;
    logic [7:0]                  r_pending_id, n_pending_id;
    logic [6:0]                  r_active_id, n_active_id;
    logic [clsh_pkg::RATE_W-1:0] r_pending_rate, n_pending_rate;
    logic                        r_rate_err, n_rate_err;
    logic [clsh_pkg::RATE_W-1:0] r_active_rate, n_active_rate;
    logic                        r_out_valid;
    clsh_pkg::t_result           r_out, n_out;
    logic                        cfg_mode;
    logic                        pop;

    assign cfg_mode    = (r_mode == clsh_pkg::MODE_CONFIG);
    assign o_cmd_ready = !r_out_valid || i_ready;
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_mode         = r_mode;
        n_stage        = r_stage;
        n_pending_id   = r_pending_id;
        n_active_id    = r_active_id;
        n_pending_rate = r_pending_rate;
        n_rate_err     = r_rate_err;
        n_active_rate  = r_active_rate;
        n_out          = '0;
        n_out.status   = clsh_pkg::ST_ERROR;

        case (i_cmd.kind)
            clsh_pkg::K_GLOBAL: begin
                n_mode            = i_cmd.arg1;
                n_out.mode_notify = 1'b1;
                n_out.status      = clsh_pkg::ST_OK;
            end
            clsh_pkg::K_SEL_VENDOR: begin
                // vendor restarts the match from any stage
                if (i_cmd.id_match) begin
                    n_stage = STAGE_VENDOR;
                end else begin
                    n_stage = STAGE_NONE;
                    n_mode  = clsh_pkg::MODE_WAITING;
                end
            end
            clsh_pkg::K_SEL_PROD: begin
                if (r_stage == STAGE_VENDOR && i_cmd.id_match) begin
                    n_stage = STAGE_PRODUCT;
                end else begin
                    n_stage = STAGE_NONE;
                    n_mode  = clsh_pkg::MODE_WAITING;
                end
            end
            clsh_pkg::K_SEL_REV: begin
                if (r_stage == STAGE_PRODUCT && i_cmd.id_match) begin
                    n_stage = STAGE_REVISION;
                end else begin
                    n_stage = STAGE_NONE;
                    n_mode  = clsh_pkg::MODE_WAITING;
                end
            end
            clsh_pkg::K_SEL_SERIAL: begin
                if (r_stage == STAGE_REVISION && i_cmd.id_match) begin
                    n_stage = STAGE_SERIAL;
                    n_mode  = (r_mode == clsh_pkg::MODE_WAITING) ? clsh_pkg::MODE_CONFIG
                                                                 : clsh_pkg::MODE_WAITING;
                    n_out.tx_valid    = 1'b1;
                    n_out.tx_command  = clsh_pkg::CS_SEL_CONFIRM;
                    n_out.mode_notify = 1'b1;
                    n_out.status      = clsh_pkg::ST_OK;
                end else begin
                    n_stage = STAGE_NONE;
                    n_mode  = clsh_pkg::MODE_WAITING;
                end
            end
            clsh_pkg::K_CFG_NODE: begin
                if (cfg_mode) begin
                    if (i_cmd.node_ok) begin
                        n_pending_id = i_cmd.arg1;
                    end else begin
                        n_out.tx_error = clsh_pkg::ERR_FAIL;
                    end
                    n_out.tx_valid   = 1'b1;
                    n_out.tx_command = clsh_pkg::CS_CFG_NODE_ID;
                    n_out.status     = clsh_pkg::ST_OK;
                end
            end
            clsh_pkg::K_CFG_TIMING: begin
                if (cfg_mode) begin
                    if (i_cmd.rate_ok) begin
                        n_pending_rate = i_cmd.rate;
                        n_out.status   = clsh_pkg::ST_OK;
                    end else begin
                        n_out.tx_error = clsh_pkg::ERR_FAIL;
                        n_out.status   = clsh_pkg::ST_RATE;
                    end
                    n_rate_err       = !i_cmd.rate_ok;
                    n_out.tx_valid   = 1'b1;
                    n_out.tx_command = clsh_pkg::CS_CFG_TIMING;
                end
            end
            clsh_pkg::K_ACT_TIMING: begin
                if (cfg_mode) begin
                    n_out.switch_delay = {i_cmd.arg2, i_cmd.arg1};
                    if (!r_rate_err) begin
                        n_active_rate     = r_pending_rate;
                        n_out.rate_switch = 1'b1;
                    end
                end
            end
            clsh_pkg::K_STORE: begin
                if (cfg_mode) begin
                    n_out.tx_valid   = 1'b1;
                    n_out.tx_command = clsh_pkg::CS_STORE;
                end
            end
            clsh_pkg::K_NMT: begin
                if ((i_cmd.arg1 == {1'b0, r_active_id} || i_cmd.arg1 == 8'd0)
                    && r_pending_id inside {[8'd1:8'd127]}) begin
                    n_active_id = r_pending_id[6:0];
                end
            end
            default: ;
        endcase

        n_out.mode         = n_mode;
        n_out.active_node  = n_active_id;
        n_out.pending_node = n_pending_id;
        n_out.active_rate  = n_active_rate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= clsh_pkg::MODE_WAITING;
            r_stage        <= STAGE_NONE;
            r_pending_id   <= '0;
            r_active_id    <= '0;
            r_pending_rate <= '0;
            r_rate_err     <= 1'b1;
            r_active_rate  <= '0;
            r_out_valid    <= 1'b0;
        end else if (pop) begin
            r_mode         <= n_mode;
            r_stage        <= n_stage;
            r_pending_id   <= n_pending_id;
            r_active_id    <= n_active_id;
            r_pending_rate <= n_pending_rate;
            r_rate_err     <= n_rate_err;
            r_active_rate  <= n_active_rate;
            r_out_valid    <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> design/canopen_lss_slave_frame_handler_unit.sv
// Channel    Handshake                       Payload
// s_axis     i_s_axis_tvalid/o_s_axis_tready received CAN frame (tdata)
// m_axis     o_m_axis_tvalid/i_m_axis_tready handler result (tdata)
// cfg        i_cfg_valid/o_cfg_ready         identity register index and data
//
// One frame per cycle sustained while the output is not stalled: the front
// classifies into a two-entry queue, the back updates state into the output
// register. Input ready depends on queue fill only, so a stalled output
// register backs up the queue before the input stalls. Reset is synchronous and
// needs no clearing pass; configuration writes are always taken.
`default_nettype none

module canopen_lss_slave_frame_handler_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // frame_id, frame_len, byte_0 .. byte_7, one zero pad bit
    input  wire logic [clsh_pkg::IN_W-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // tx_valid, tx_command, tx_error, mode, mode_notify, active_node,
    // pending_node, active_rate, rate_switch, switch_delay, status
    output logic [clsh_pkg::OUT_W-1:0]          o_m_axis_tdata,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [clsh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data
);

    clsh_pkg::t_cmd    front_cmd;
    clsh_pkg::t_cmd    queue_cmd;
    clsh_pkg::t_result result;
    logic              queue_valid;
    logic              back_ready;

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = result;

    clsh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_frame_id  (i_s_axis_tdata[10:0]),
        .i_frame_len (i_s_axis_tdata[14:11]),
        .i_bytes     (i_s_axis_tdata[78:15]),
        .o_cmd       (front_cmd)
    );

    clsh_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_s_axis_tvalid),
        .o_wr_ready (o_s_axis_tready),
        .i_wr_data  (front_cmd),
        .o_rd_valid (queue_valid),
        .i_rd_ready (back_ready),
        .o_rd_data  (queue_cmd)
    );

    clsh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (back_ready),
        .i_cmd       (queue_cmd),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_result    (result)
    );

endmodule

`default_nettype wire

>>> design/clsh_checker.sv
`default_nettype none
`include "canopen_lss_slave_frame_handler_unit_macros.svh"

module clsh_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_m_axis_tvalid,
    input wire logic                      i_m_axis_tready,
    input wire logic [clsh_pkg::OUT_W-1:0] o_m_axis_tdata
);

    `CLSH_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // no response frame means zero response bytes
    `CLSH_ASSERT_IMP(a_quiet_tx, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[0], o_m_axis_tdata[16:1] == 16'd0)

    `CLSH_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[79:78] != 2'd3)

    // an activate never answers
    `CLSH_ASSERT_IMP(a_switch_silent, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[61], !o_m_axis_tdata[0] && o_m_axis_tdata[79:78] == 2'd1)

    // unsupported rate always answers with the error code
    `CLSH_ASSERT_IMP(a_rate_reply, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[79:78] == 2'd2, o_m_axis_tdata[0] && o_m_axis_tdata[16:9] == 8'd1)

endmodule

bind canopen_lss_slave_frame_handler_unit clsh_checker u_clsh_checker (.*);

`default_nettype wire

>>> tb/canopen_lss_slave_frame_handler_unit_test.sv
`timescale 1ns / 100ps

module canopen_lss_slave_frame_handler_unit_test;

    import clsh_pkg::*;

    localparam int unsigned LONG_HOLD      = 200;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_ITEMS   = 700;
    localparam int unsigned PHASES         = 4;

    localparam int unsigned TABLE0_RATE [9] = '{
        1000000, 800000, 500000, 250000, 125000, 0, 50000, 20000, 10000
    };
    localparam logic [7:0] SEL_CS [4] = '{
        CS_SEL_VENDOR, CS_SEL_PRODUCT, CS_SEL_REVISION, CS_SEL_SERIAL
    };
    localparam logic [CFG_IDX_W-1:0] REG_IDX [4] = '{
        REG_VENDOR, REG_PRODUCT, REG_REVISION, REG_SERIAL
    };

    typedef enum logic [2:0] {
        STG_NONE, STG_VENDOR, STG_PRODUCT, STG_REVISION, STG_SERIAL
    } match_stage_e;

    // byte 7 down to byte 0, then length and id: same order as tdata
    typedef struct packed {
        logic [7:0][7:0] pay;
        logic [3:0]      flen;
        logic [10:0]     fid;
    } can_frame_t;

    typedef struct packed {
        can_frame_t frame;
        logic       pinned;
        t_result    want;
    } lss_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_valid   = 1'b0;
    logic [IN_W-1:0]      s_data    = '0;
    logic                 m_ready   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 bursty    = 1'b1;
    logic                 hold_req  = 1'b0;
    wire                  s_ready;
    wire                  m_valid;
    wire  [OUT_W-1:0]     m_data;
    wire                  cfg_ready;

    // identity registers and the handler state as the checker sees them
    logic [31:0]  ident [4]      = '{default: '0};
    logic [31:0]  next_ident [4];
    logic [7:0]   lss_mode       = MODE_WAITING;
    match_stage_e stage          = STG_NONE;
    logic [7:0]   pend_node      = '0;
    logic [6:0]   act_node       = '0;
    logic [19:0]  pend_rate      = '0;
    logic [19:0]  act_rate       = '0;
    logic         rate_bad       = 1'b1;

    t_result      replies_due [$];
    lss_row_t     dir_rows [$];
    int unsigned  mismatches     = 0;
    int unsigned  stalled        = 0;

    canopen_lss_slave_frame_handler_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic can_frame_t mk_frame(input logic [10:0] fid, input logic [3:0] flen,
                                            input logic [7:0] b0, b1, b2, b3, b4);
        can_frame_t f;
        f.fid    = fid;
        f.flen   = flen;
        f.pay[0] = b0;
        f.pay[1] = b1;
        f.pay[2] = b2;
        f.pay[3] = b3;
        f.pay[4] = b4;
        f.pay[5] = 8'($urandom);
        f.pay[6] = 8'($urandom);
        f.pay[7] = 8'($urandom);
        return f;
    endfunction

    function automatic can_frame_t sel_frame(input logic [7:0] cs, input logic [31:0] w);
        return mk_frame(LSS_RX_ID, LSS_LEN, cs, w[7:0], w[15:8], w[23:16], w[31:24]);
    endfunction

    function automatic lss_row_t plain(input can_frame_t f);
        lss_row_t r;
        r       = '0;
        r.frame = f;
        return r;
    endfunction

    function automatic lss_row_t with_reply(input can_frame_t f, input logic tv,
                                            input logic [7:0] cmd, err, md,
                                            input logic [1:0] st);
        lss_row_t r;
        r                 = plain(f);
        r.pinned          = 1'b1;
        r.want.tx_valid   = tv;
        r.want.tx_command = cmd;
        r.want.tx_error   = err;
        r.want.mode       = md;
        r.want.status     = st;
        return r;
    endfunction

    // A broken step of the selective switch clears the match and drops to waiting.
    function automatic logic match_step(input match_stage_e from, input match_stage_e to,
                                        input logic [31:0] want, input logic [31:0] got);
        if (stage == from && want == got) begin
            stage = to;
            return 1'b1;
        end
        stage    = STG_NONE;
        lss_mode = MODE_WAITING;
        return 1'b0;
    endfunction

    function automatic t_result lss_frame_response(input can_frame_t f);
        t_result     r;
        logic [31:0] word;
        logic        cfg_mode;
        int unsigned rate;
        r        = '0;
        r.status = ST_ERROR;
        word     = {f.pay[4], f.pay[3], f.pay[2], f.pay[1]};
        cfg_mode = (lss_mode == MODE_CONFIG);
        if (f.fid == LSS_RX_ID && f.flen == LSS_LEN) begin
            case (f.pay[0])
                CS_SWITCH_GLOBAL: begin
                    lss_mode      = f.pay[1];
                    r.mode_notify = 1'b1;
                    r.status      = ST_OK;
                end
                CS_SEL_VENDOR: begin
                    // vendor restarts the match from any stage
                    if (word == ident[REG_VENDOR]) begin
                        stage = STG_VENDOR;
                    end else begin
                        stage    = STG_NONE;
                        lss_mode = MODE_WAITING;
                    end
                end
                CS_SEL_PRODUCT:
                    void'(match_step(STG_VENDOR, STG_PRODUCT, ident[REG_PRODUCT], word));
                CS_SEL_REVISION:
                    void'(match_step(STG_PRODUCT, STG_REVISION, ident[REG_REVISION], word));
                CS_SEL_SERIAL: begin
                    if (match_step(STG_REVISION, STG_SERIAL, ident[REG_SERIAL], word)) begin
                        lss_mode      = (lss_mode == MODE_WAITING) ? MODE_CONFIG : MODE_WAITING;
                        r.tx_valid    = 1'b1;
                        r.tx_command  = CS_SEL_CONFIRM;
                        r.mode_notify = 1'b1;
                        r.status      = ST_OK;
                    end
                end
                CS_CFG_NODE_ID: if (cfg_mode) begin
                    if ((f.pay[1] >= 8'd1 && f.pay[1] <= 8'h7F) || f.pay[1] == 8'hFF) begin
                        pend_node = f.pay[1];
                    end else begin
                        r.tx_error = ERR_FAIL;
                    end
                    r.tx_valid   = 1'b1;
                    r.tx_command = CS_CFG_NODE_ID;
                    r.status     = ST_OK;
                end
                CS_CFG_TIMING: if (cfg_mode) begin
                    rate = (f.pay[2] < 8'd9) ? TABLE0_RATE[f.pay[2]] : 0;
                    if (f.pay[1] == 8'h00 && rate != 0) begin
                        pend_rate = 20'(rate);
                        r.status  = ST_OK;
                    end else begin
                        r.tx_error = ERR_FAIL;
                        r.status   = ST_RATE;
                    end
                    rate_bad     = (r.tx_error != ERR_NONE);
                    r.tx_valid   = 1'b1;
                    r.tx_command = CS_CFG_TIMING;
                end
                CS_ACT_TIMING: if (cfg_mode) begin
                    r.switch_delay = {f.pay[2], f.pay[1]};
                    if (!rate_bad) begin
                        act_rate      = pend_rate;
                        r.rate_switch = 1'b1;
                    end
                end
                CS_STORE: if (cfg_mode) begin
                    r.tx_valid   = 1'b1;
                    r.tx_command = CS_STORE;
                end
                default: ;
            endcase
        end else if (f.fid == NMT_ID && f.flen == NMT_LEN) begin
            if (f.pay[0] == NMT_RESET_COMM &&
                (f.pay[1] == {1'b0, act_node} || f.pay[1] == 8'h00) &&
                pend_node >= 8'd1 && pend_node <= 8'h7F) begin
                act_node = pend_node[6:0];
            end
        end
        r.mode         = lss_mode;
        r.active_node  = act_node;
        r.pending_node = pend_node;
        r.active_rate  = act_rate;
        return r;
    endfunction

    task automatic send_frame(input lss_row_t r);
        t_result predicted;
        if (bursty && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {1'b0, r.frame};
        do @(posedge clk); while (!s_ready);
        predicted = lss_frame_response(r.frame);
        if (r.pinned) begin
            predicted.tx_valid   = r.want.tx_valid;
            predicted.tx_command = r.want.tx_command;
            predicted.tx_error   = r.want.tx_error;
            predicted.mode       = r.want.mode;
            predicted.status     = r.want.status;
        end
        replies_due.push_back(predicted);
    endtask

    task automatic program_ident();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_IDX[i];
            cfg_data  <= next_ident[i];
            do @(posedge clk); while (!cfg_ready);
            ident[i] = next_ident[i];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (replies_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One scenario: a selective sequence counts as its frames, noise counts as none.
    task automatic send_random_round(output int unsigned counted);
        can_frame_t  f;
        int unsigned pick;
        logic [31:0] w;
        int          broken;
        counted = 1;
        pick    = $urandom_range(0, 99);
        f = mk_frame(LSS_RX_ID, LSS_LEN, CS_STORE, 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
        if (pick < 35) begin
            // now and then one step is corrupted or dropped
            broken  = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 3)) : -1;
            counted = 0;
            for (int k = 0; k < 4; k++) begin
                w = ident[k];
                if (k == broken) begin
                    if ($urandom_range(0, 1) == 0) continue;
                    w = w ^ (32'd1 << $urandom_range(0, 31));
                end
                send_frame(plain(sel_frame(SEL_CS[k], w)));
                counted++;
            end
            return;
        end
        if (pick < 45) begin
            f.pay[0] = CS_SWITCH_GLOBAL;
            case ($urandom_range(0, 3))
                0:       f.pay[1] = MODE_WAITING;
                1, 2:    f.pay[1] = MODE_CONFIG;
                default: ;
            endcase
        end else if (pick < 60) begin
            f.pay[0] = CS_CFG_NODE_ID;
            case ($urandom_range(0, 5))
                0:       f.pay[1] = 8'hFF;
                1, 2, 3: f.pay[1] = 8'($urandom_range(1, 127));
                default: ;
            endcase
        end else if (pick < 75) begin
            f.pay[0] = CS_CFG_TIMING;
            if ($urandom_range(0, 5) != 0) f.pay[1] = 8'h00;
            if ($urandom_range(0, 4) != 0) f.pay[2] = 8'($urandom_range(0, 9));
        end else if (pick < 83) begin
            f.pay[0] = CS_ACT_TIMING;
        end else if (pick < 88) begin
            f.pay[0] = CS_STORE;
        end else if (pick < 95) begin
            f.fid = NMT_ID;
            if ($urandom_range(0, 9) != 0) f.flen = NMT_LEN;
            if ($urandom_range(0, 6) != 0) f.pay[0] = NMT_RESET_COMM;
            case ($urandom_range(0, 4))
                0, 1:    f.pay[1] = {1'b0, act_node};
                2, 3:    f.pay[1] = 8'h00;
                default: ;
            endcase
        end else begin
            f.fid    = 11'($urandom);
            f.flen   = 4'($urandom_range(0, 8));
            f.pay[0] = 8'($urandom);
            if ($urandom_range(0, 1) == 0) f.fid = LSS_RX_ID;
            counted  = 0;
        end
        send_frame(plain(f));
    endtask

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_result observed;
        t_result predicted;
        if (m_valid && m_ready) begin
            observed = t_result'(m_data);
            if (replies_due.size() == 0) begin
                $error("result transfer with nothing outstanding: %h", m_data);
                mismatches++;
            end else begin
                predicted = replies_due.pop_front();
                check_field("tx_valid", predicted.tx_valid, observed.tx_valid);
                check_field("tx_command", predicted.tx_command, observed.tx_command);
                check_field("tx_error", predicted.tx_error, observed.tx_error);
                check_field("mode", predicted.mode, observed.mode);
                check_field("mode_notify", predicted.mode_notify, observed.mode_notify);
                check_field("active_node", predicted.active_node, observed.active_node);
                check_field("pending_node", predicted.pending_node, observed.pending_node);
                check_field("active_rate", predicted.active_rate, observed.active_rate);
                check_field("rate_switch", predicted.rate_switch, observed.rate_switch);
                check_field("switch_delay", predicted.switch_delay, observed.switch_delay);
                check_field("status", predicted.status, observed.status);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stalled <= 0;
        end else if (stalled == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stalled <= stalled + 1;
        end
    end

    initial begin : result_sink
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                // long hold: the queue fills and the input must stall
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (bursty && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        int unsigned counted;
        int unsigned n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        next_ident = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h5AC3_0F96, 32'h8000_0001};
        program_ident();

        dir_rows.push_back(with_reply(mk_frame(LSS_RX_ID, LSS_LEN, CS_CFG_NODE_ID, 8'd5,
            8'h00, 8'h00, 8'h00), 1'b0, 8'h00, ERR_NONE, MODE_WAITING, ST_ERROR));
        dir_rows.push_back(with_reply(mk_frame(11'h7FF, LSS_LEN, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'hFF), 1'b0, 8'h00, ERR_NONE, MODE_WAITING, ST_ERROR));
        dir_rows.push_back(with_reply(mk_frame(LSS_RX_ID, LSS_LEN, CS_SWITCH_GLOBAL,
            MODE_CONFIG, 8'h00, 8'h00, 8'h00), 1'b0, 8'h00, ERR_NONE, MODE_CONFIG, ST_OK));
        dir_rows.push_back(with_reply(mk_frame(LSS_RX_ID, LSS_LEN, CS_CFG_NODE_ID, 8'h00,
            8'h00, 8'h00, 8'h00), 1'b1, CS_CFG_NODE_ID, ERR_FAIL, MODE_CONFIG, ST_OK));
        dir_rows.push_back(with_reply(mk_frame(LSS_RX_ID, LSS_LEN, CS_CFG_NODE_ID, 8'h80,
            8'hFF, 8'hFF, 8'hFF), 1'b1, CS_CFG_NODE_ID, ERR_FAIL, MODE_CONFIG, ST_OK));
        dir_rows.push_back(with_reply(mk_frame(LSS_RX_ID, LSS_LEN, CS_CFG_NODE_ID, 8'hFF,
            8'h00, 8'h00, 8'h00), 1'b1, CS_CFG_NODE_ID, ERR_NONE, MODE_CONFIG, ST_OK));
        // pending id 255 is never made active
        dir_rows.push_back(with_reply(mk_frame(NMT_ID, NMT_LEN, NMT_RESET_COMM, 8'h00,
            8'h00, 8'h00, 8'h00), 1'b0, 8'h00, ERR_NONE, MODE_CONFIG, ST_ERROR));
        dir_rows.push_back(plain(mk_frame(LSS_RX_ID, LSS_LEN, CS_CFG_NODE_ID, 8'h7F,
            8'h00, 8'h00, 8'h00)));
        dir_rows.push_back(plain(mk_frame(LSS_RX_ID, LSS_LEN, CS_CFG_NODE_ID, 8'h01,
            8'h00, 8'h00, 8'h00)));
        dir_rows.push_back(with_reply(mk_frame(LSS_RX_ID, LSS_LEN, CS_CFG_TIMING, 8'h00,
            8'd5, 8'h00, 8'h00), 1'b1, CS_CFG_TIMING, ERR_FAIL, MODE_CONFIG, ST_RATE));
        dir_rows.push_back(with_reply(mk_frame(LSS_RX_ID, LSS_LEN, CS_CFG_TIMING, 8'hFF,
            8'h00, 8'h00, 8'h00), 1'b1, CS_CFG_TIMING, ERR_FAIL, MODE_CONFIG, ST_RATE));
        dir_rows.push_back(with_reply(mk_frame(LSS_RX_ID, LSS_LEN, CS_CFG_TIMING, 8'h00,
            8'd9, 8'h00, 8'h00), 1'b1, CS_CFG_TIMING, ERR_FAIL, MODE_CONFIG, ST_RATE));
        dir_rows.push_back(plain(mk_frame(LSS_RX_ID, LSS_LEN, CS_ACT_TIMING, 8'h34,
            8'h12, 8'h00, 8'h00)));
        dir_rows.push_back(with_reply(mk_frame(LSS_RX_ID, LSS_LEN, CS_CFG_TIMING, 8'h00,
            8'd8, 8'h00, 8'h00), 1'b1, CS_CFG_TIMING, ERR_NONE, MODE_CONFIG, ST_OK));
        dir_rows.push_back(plain(mk_frame(LSS_RX_ID, LSS_LEN, CS_ACT_TIMING, 8'hFF,
            8'hFF, 8'hFF, 8'hFF)));
        dir_rows.push_back(with_reply(mk_frame(LSS_RX_ID, LSS_LEN, CS_STORE, 8'h00,
            8'h00, 8'h00, 8'h00), 1'b1, CS_STORE, ERR_NONE, MODE_CONFIG, ST_ERROR));
        dir_rows.push_back(plain(mk_frame(LSS_RX_ID, LSS_LEN, CS_CFG_TIMING, 8'h00,
            8'h00, 8'h00, 8'h00)));
        dir_rows.push_back(plain(mk_frame(LSS_RX_ID, LSS_LEN, CS_ACT_TIMING, 8'h00,
            8'h00, 8'h00, 8'h00)));
        dir_rows.push_back(plain(mk_frame(NMT_ID, NMT_LEN, NMT_RESET_COMM, 8'h00,
            8'h00, 8'h00, 8'h00)));
        dir_rows.push_back(with_reply(mk_frame(LSS_RX_ID, LSS_LEN, CS_SWITCH_GLOBAL,
            8'hFF, 8'h00, 8'h00, 8'h00), 1'b0, 8'h00, ERR_NONE, 8'hFF, ST_OK));
        // full selective match from a mode that is not waiting drops to waiting
        for (int k = 0; k < 3; k++) begin
            dir_rows.push_back(plain(sel_frame(SEL_CS[k], next_ident[k])));
        end
        dir_rows.push_back(with_reply(sel_frame(CS_SEL_SERIAL, next_ident[REG_SERIAL]),
            1'b1, CS_SEL_CONFIRM, ERR_NONE, MODE_WAITING, ST_OK));
        dir_rows.push_back(plain(sel_frame(CS_SEL_PRODUCT, next_ident[REG_PRODUCT])));

        foreach (dir_rows[i]) send_frame(dir_rows[i]);
        s_valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            for (int i = 0; i < 4; i++) begin
                case (ph)
                    0:       next_ident[i] = '0;
                    1:       next_ident[i] = '1;
                    default: next_ident[i] = $urandom;
                endcase
            end
            program_ident();
            if (ph == PHASES - 1) bursty <= 1'b0;
            counted = 0;
            while (counted < RANDOM_ITEMS / PHASES) begin
                send_random_round(n);
                counted += n;
                if (ph == 1 && counted >= 80) hold_req <= 1'b1;
            end
            s_valid <= 1'b0;
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
